// ===== hw/rtl/mi_pkg.sv =====
// Shared constants, types and the sequencer states of the 4x4 matrix inverse core.
package mi_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int COF_W           = 64;
    localparam int ADDR_W          = 5;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_WAIT,
        ST_COF,
        ST_DRD,
        ST_DMUL,
        ST_DWAIT,
        ST_DET,
        ST_QRD,
        ST_QGO,
        ST_QWAIT,
        ST_EMIT
    } t_state;

    // Element read request from the back end to the matrix buffers
    typedef struct packed {
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
    } t_rd_req;

    // Head of the job queue: a loaded matrix buffer waiting for the back end
    typedef struct packed {
        logic valid;
        logic bank;
    } t_job;

endpackage

// ===== hw/rtl/matrix_inverse_4x4_core.sv =====
// Timing is set by the shared chunked multiplier and the divider; a singular matrix skips
//   the divisions and its results are emitted without them.
// Throughput: one element per cycle while loading, unless busy is high with both buffers full;
//   a second matrix loads into the other buffer while the first is worked; results leave one per division.
// Reset: synchronous active-low; clears load count, queue, sequencer and strobe.
// Results are strobed for one cycle; the receiver cannot stall them.
module matrix_inverse_4x4_core #(
    parameter int FRAC_BITS   = mi_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = mi_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_elem_value,
    output logic                          o_valid,
    output logic signed [VALUE_WIDTH-1:0] o_inv_value,
    output logic [1:0]                    o_out_row,
    output logic [1:0]                    o_out_col,
    output logic                          o_is_singular,
    output logic                          o_did_saturate,
    output logic                          o_out_last
);
    import mi_pkg::*;

    t_rd_req                       rd;
    t_job                          job;
    logic                          pop;
    logic signed [VALUE_WIDTH-1:0] rdata0, rdata1;

    mi_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_elem_value (i_elem_value),
        .i_rd         (rd),
        .o_rdata0     (rdata0),
        .o_rdata1     (rdata1),
        .o_job        (job),
        .i_pop        (pop)
    );

    mi_back #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job),
        .o_pop          (pop),
        .o_rd           (rd),
        .i_rdata0       (rdata0),
        .i_rdata1       (rdata1),
        .o_valid        (o_valid),
        .o_inv_value    (o_inv_value),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_is_singular  (o_is_singular),
        .o_did_saturate (o_did_saturate),
        .o_out_last     (o_out_last)
    );

endmodule

// ===== hw/rtl/mi_front.sv =====
// Front end: loads elements into two matrix buffers and queues completed matrices.
module mi_front #(
    parameter int VALUE_WIDTH = mi_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [VALUE_WIDTH-1:0] i_elem_value,
    input  mi_pkg::t_rd_req               i_rd,
    output logic signed [VALUE_WIDTH-1:0] o_rdata0,
    output logic signed [VALUE_WIDTH-1:0] o_rdata1,
    output mi_pkg::t_job                  o_job,
    input  logic                          i_pop
);
    import mi_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [VALUE_WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [VALUE_WIDTH-1:0] r_rd0, r_rd1;
    logic [3:0]             r_cnt, n_cnt;
    logic                   r_wbank, n_wbank;
    logic                   r_q [0:1];
    logic                   r_hd, n_hd, r_tl, n_tl;
    logic [1:0]             r_qcnt, n_qcnt;
    logic                   accept, push;

    // Accept an item while a buffer is free
    assign o_busy = (r_qcnt == 2'd2);
    assign accept = i_start & ~o_busy;
    assign push   = accept & (r_cnt == 4'd15);

    assign o_rdata0   = r_rd0;
    assign o_rdata1   = r_rd1;
    assign o_job.valid = (r_qcnt != 2'd0);
    assign o_job.bank  = r_q[r_hd];

    // Next load position and queue pointers
    always_comb begin
        n_cnt   = accept ? r_cnt + 4'd1 : r_cnt;
        n_wbank = push ? ~r_wbank : r_wbank;
        n_tl    = push ? ~r_tl : r_tl;
        n_hd    = i_pop ? ~r_hd : r_hd;
        n_qcnt  = r_qcnt;
        if (push && !i_pop) begin
            n_qcnt = r_qcnt + 2'd1;
        end else if (!push && i_pop) begin
            n_qcnt = r_qcnt - 2'd1;
        end
    end

    // Buffer writes and registered reads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[{r_wbank, r_cnt}] <= i_elem_value;
        end
        r_rd0 <= r_mem[i_rd.addr0];
        r_rd1 <= r_mem[i_rd.addr1];
        if (push) begin
            r_q[r_tl] <= r_wbank;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wbank <= 1'b0;
            r_hd    <= 1'b0;
            r_tl    <= 1'b0;
            r_qcnt  <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_wbank <= n_wbank;
            r_hd    <= n_hd;
            r_tl    <= n_tl;
            r_qcnt  <= n_qcnt;
        end
    end

endmodule

// ===== hw/rtl/mi_mul.sv =====
// Shared multiplier: element times a wide operand, one element-wide chunk per cycle.
module mi_mul #(
    parameter int VALUE_WIDTH = mi_pkg::VALUE_WIDTH_DEF,
    parameter int B_W         = 2 * mi_pkg::VALUE_WIDTH_DEF + 1,
    parameter int NCH         = (B_W + VALUE_WIDTH - 1) / VALUE_WIDTH,
    parameter int PW          = VALUE_WIDTH * (NCH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [B_W-1:0]         i_b,
    output logic                          o_done,
    output logic signed [PW-1:0]          o_p
);
    import mi_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int BPW   = NCH * W;
    localparam int CNT_W = $clog2(NCH);

    logic signed [W-1:0]   r_a;
    logic [BPW-1:0]        r_b;
    logic signed [PW-1:0]  r_acc;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_run, n_run, r_done, n_done;
    logic                  first;
    logic signed [W:0]     chunk;
    logic signed [2*W:0]   prod;

    // Top chunk is signed, the lower ones unsigned
    assign first = (r_cnt == CNT_W'(NCH - 1));
    assign chunk = first ? {r_b[BPW-1], r_b[BPW-1 -: W]} : {1'b0, r_b[BPW-1 -: W]};
    assign prod  = r_a * chunk;

    assign o_done = r_done;
    assign o_p    = r_acc;

    // Sequence the chunks
    always_comb begin
        n_run  = r_run;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = CNT_W'(NCH - 1);
        end else if (r_run) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BPW'(i_b);
            r_acc <= '0;
        end else if (r_run) begin
            r_b   <= r_b << W;
            r_acc <= (r_acc <<< W) + PW'(prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

endmodule

// ===== hw/rtl/mi_div.sv =====
// Restoring divider for magnitudes, one quotient bit per cycle.
module mi_div #(
    parameter int NB = mi_pkg::COF_W + mi_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [NB-1:0]            i_num,
    input  logic [mi_pkg::COF_W-1:0] i_den,
    output logic                     o_done,
    output logic [NB-1:0]            o_quot
);
    import mi_pkg::*;

    localparam int CNT_W = $clog2(NB + 1);

    logic [NB-1:0]    r_n;
    logic [COF_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_run, n_run, r_done, n_done;
    logic [COF_W:0]   rs, diff;
    logic             ge;

    // Trial subtraction
    assign rs   = {r_rem, r_n[NB-1]};
    assign diff = rs - {1'b0, r_den};
    assign ge   = (rs >= {1'b0, r_den});

    assign o_done = r_done;
    assign o_quot = r_n;

    always_comb begin
        n_run  = r_run;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = CNT_W'(NB);
        end else if (r_run) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Shift numerator out and quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_n   <= {r_n[NB-2:0], ge};
            r_rem <= ge ? diff[COF_W-1:0] : rs[COF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

endmodule

// ===== hw/rtl/mi_back.sv =====
// Back end: cofactors, determinant and division sequencer with result registers.
module mi_back #(
    parameter int FRAC_BITS   = mi_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = mi_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mi_pkg::t_job                  i_job,
    output logic                          o_pop,
    output mi_pkg::t_rd_req               o_rd,
    input  logic signed [VALUE_WIDTH-1:0] i_rdata0,
    input  logic signed [VALUE_WIDTH-1:0] i_rdata1,
    output logic                          o_valid,
    output logic signed [VALUE_WIDTH-1:0] o_inv_value,
    output logic [1:0]                    o_out_row,
    output logic [1:0]                    o_out_col,
    output logic                          o_is_singular,
    output logic                          o_did_saturate,
    output logic                          o_out_last
);
    import mi_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int D2W = 2 * W + 1;
    localparam int BW  = (D2W > COF_W) ? D2W : COF_W;
    localparam int NCH = (BW + W - 1) / W;
    localparam int PW  = W * (NCH + 1);
    localparam int A3W = 3 * W + 3;
    localparam int CW  = (3 * W + 4 > COF_W + 2) ? 3 * W + 4 : COF_W + 2;
    localparam int DW  = W + COF_W + 2;
    localparam int NB  = COF_W + F;

    localparam logic signed [CW-1:0]   CMAX  = {{(CW - COF_W + 1){1'b0}}, {(COF_W - 1){1'b1}}};
    localparam logic signed [CW-1:0]   CMIN  = ~CMAX;
    localparam logic signed [DW-1:0]   DMAX  = {{(DW - COF_W + 1){1'b0}}, {(COF_W - 1){1'b1}}};
    localparam logic signed [DW-1:0]   DMIN  = ~DMAX;
    localparam logic [COF_W-1:0]       SMAX  = {1'b0, {(COF_W - 1){1'b1}}};
    localparam logic [COF_W-1:0]       SMIN  = ~SMAX;
    localparam logic [W-1:0]           VMAX  = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]           VMIN  = ~VMAX;
    localparam logic [NB-1:0]          QMAXP = {{(NB - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [NB-1:0]          QMAXN = QMAXP + 1'b1;
    localparam logic                   ONE_FITS = (F < W - 1);
    localparam logic [W-1:0]           ONE_VAL  =
        ONE_FITS ? ({{(W - 1){1'b0}}, 1'b1} << F) : VMAX;

    typedef enum logic [1:0] {MOP_A, MOP_B, MOP_T} t_mop;

    // Map a minor index to a matrix index, skipping the deleted line
    function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] i);
        skip_idx = (i < skip) ? i : i + 2'd1;
    endfunction

    t_state                 r_state, n_state;
    t_mop                   r_op, n_op;
    logic [3:0]             r_k, n_k;
    logic [1:0]             r_t, n_t, r_c, n_c;
    logic signed [2*W-1:0]  r_pa, n_pa;
    logic signed [D2W-1:0]  r_d, n_d;
    logic signed [A3W-1:0]  r_acc3, n_acc3;
    logic signed [DW-1:0]   r_dacc, n_dacc;
    logic [COF_W-1:0]       r_det, n_det;
    logic                   r_dsat, n_dsat;
    logic                   r_neg, n_neg, r_csel, n_csel;
    logic [COF_W-1:0]       r_cof [0:15];
    logic                   r_csat [0:15];
    logic [COF_W-1:0]       r_cof_rd;
    logic [3:0]             cof_raddr;

    logic                   r_ovalid, n_ovalid;
    logic [W-1:0]           r_oval, n_oval;
    logic [1:0]             r_orow, n_orow, r_ocol, n_ocol;
    logic                   r_osing, n_osing, r_osat, n_osat, r_olast, n_olast;
    logic                   pop;

    logic                   mul_start, mul_done;
    logic signed [BW-1:0]   mul_b;
    logic signed [PW-1:0]   mul_p;
    logic signed [2*W-1:0]  p2;
    logic signed [A3W-1:0]  term;
    logic                   div_start, div_done;
    logic [NB-1:0]          div_num, div_q;
    logic [COF_W-1:0]       cof_mag, det_mag;

    logic [1:0]             ca, cb, mr, mc;
    logic signed [CW-1:0]   cx, c_tv;
    logic [CW-1:0]          c_mag, c_sh;
    logic [COF_W-1:0]       cof_v;
    logic                   cof_sat;
    logic [DW-1:0]          d_mag, d_sh;
    logic signed [DW-1:0]   d_tv;
    logic [COF_W-1:0]       det_v;
    logic                   det_sat;
    logic                   q_sat;
    logic [W-1:0]           q_val;

    mi_mul #(.VALUE_WIDTH(W), .B_W(BW), .NCH(NCH), .PW(PW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (i_rdata0),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    mi_div #(.NB(NB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (det_mag),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Element addresses of the current minor
    assign mr = r_k[3:2];
    assign mc = r_k[1:0];
    assign ca = (r_t == 2'd0) ? 2'd1 : 2'd0;
    assign cb = (r_t == 2'd2) ? 2'd1 : 2'd2;

    always_comb begin
        o_rd.addr0 = {i_job.bank, skip_idx(mr, 2'd0), skip_idx(mc, r_t)};
        o_rd.addr1 = {i_job.bank, skip_idx(mr, 2'd2), skip_idx(mc, ca)};
        if (r_state == ST_DRD) begin
            o_rd.addr0 = {i_job.bank, 2'd0, r_c};
        end else begin
            case (r_op)
                MOP_A: begin
                    o_rd.addr0 = {i_job.bank, skip_idx(mr, 2'd1), skip_idx(mc, ca)};
                    o_rd.addr1 = {i_job.bank, skip_idx(mr, 2'd2), skip_idx(mc, cb)};
                end
                MOP_B: begin
                    o_rd.addr0 = {i_job.bank, skip_idx(mr, 2'd1), skip_idx(mc, cb)};
                    o_rd.addr1 = {i_job.bank, skip_idx(mr, 2'd2), skip_idx(mc, ca)};
                end
                default: begin
                end
            endcase
        end
    end

    // Multiplier operands and products
    assign mul_start = (r_state == ST_MUL) || (r_state == ST_DMUL);
    assign mul_b     = (r_state == ST_DMUL) ? BW'($signed(r_cof_rd)) :
                       (r_op == MOP_T) ? BW'(r_d) : BW'(i_rdata1);
    assign p2        = (2 * W)'(mul_p);
    assign term      = A3W'(mul_p);

    // Signed cofactor: sign, truncate toward zero, clip to 64 bits
    always_comb begin
        cx = CW'(r_acc3);
        if (r_k[2] ^ r_k[0]) begin
            cx = -cx;
        end
        c_mag   = cx[CW-1] ? CW'(-cx) : CW'(cx);
        c_sh    = c_mag >> (2 * F);
        c_tv    = cx[CW-1] ? -$signed(c_sh) : $signed(c_sh);
        cof_sat = (c_tv > CMAX) || (c_tv < CMIN);
        cof_v   = (c_tv > CMAX) ? SMAX : (c_tv < CMIN) ? SMIN : c_tv[COF_W-1:0];
    end

    // Determinant: truncate toward zero, clip to 64 bits
    always_comb begin
        d_mag   = r_dacc[DW-1] ? DW'(-r_dacc) : DW'(r_dacc);
        d_sh    = d_mag >> F;
        d_tv    = r_dacc[DW-1] ? -$signed(d_sh) : $signed(d_sh);
        det_sat = (d_tv > DMAX) || (d_tv < DMIN);
        det_v   = (d_tv > DMAX) ? SMAX : (d_tv < DMIN) ? SMIN : d_tv[COF_W-1:0];
    end

    // Division operands and the clipped quotient
    assign cof_mag   = r_cof_rd[COF_W-1] ? -r_cof_rd : r_cof_rd;
    assign det_mag   = r_det[COF_W-1] ? -r_det : r_det;
    assign div_num   = {cof_mag, {F{1'b0}}};
    assign div_start = (r_state == ST_QGO);
    assign q_sat     = r_neg ? (div_q > QMAXN) : (div_q > QMAXP);
    assign q_val     = q_sat ? (r_neg ? VMIN : VMAX) :
                       (r_neg ? W'(-div_q) : div_q[W-1:0]);

    // Cofactor store address: transposed during division
    assign cof_raddr = (r_state == ST_DRD) ? {2'b00, r_c} : {r_k[1:0], r_k[3:2]};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_job.valid) n_state = ST_RD;
            ST_RD:    n_state = ST_MUL;
            ST_MUL:   n_state = ST_WAIT;
            ST_WAIT: begin
                if (mul_done) begin
                    n_state = (r_op == MOP_T && r_t == 2'd2) ? ST_COF : ST_RD;
                end
            end
            ST_COF:   n_state = (r_k == 4'd15) ? ST_DRD : ST_RD;
            ST_DRD:   n_state = ST_DMUL;
            ST_DMUL:  n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (mul_done) begin
                    n_state = (r_c == 2'd3) ? ST_DET : ST_DRD;
                end
            end
            ST_DET:   n_state = (det_v == '0) ? ST_EMIT : ST_QRD;
            ST_QRD:   n_state = ST_QGO;
            ST_QGO:   n_state = ST_QWAIT;
            ST_QWAIT: begin
                if (div_done) begin
                    n_state = (r_k == 4'd15) ? ST_IDLE : ST_QRD;
                end
            end
            ST_EMIT:  if (r_k == 4'd15) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and result updates
    always_comb begin
        n_op     = r_op;
        n_k      = r_k;
        n_t      = r_t;
        n_c      = r_c;
        n_pa     = r_pa;
        n_d      = r_d;
        n_acc3   = r_acc3;
        n_dacc   = r_dacc;
        n_det    = r_det;
        n_dsat   = r_dsat;
        n_neg    = r_neg;
        n_csel   = r_csel;
        n_ovalid = 1'b0;
        n_oval   = r_oval;
        n_orow   = r_orow;
        n_ocol   = r_ocol;
        n_osing  = r_osing;
        n_osat   = r_osat;
        n_olast  = r_olast;
        pop      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_k    = '0;
                n_t    = '0;
                n_op   = MOP_A;
                n_acc3 = '0;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    case (r_op)
                        MOP_A: begin
                            n_pa = p2;
                            n_op = MOP_B;
                        end
                        MOP_B: begin
                            n_d  = D2W'(r_pa) - D2W'(p2);
                            n_op = MOP_T;
                        end
                        MOP_T: begin
                            n_acc3 = (r_t == 2'd1) ? r_acc3 - term : r_acc3 + term;
                            if (r_t != 2'd2) begin
                                n_t  = r_t + 2'd1;
                                n_op = MOP_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COF: begin
                n_k    = r_k + 4'd1;
                n_t    = '0;
                n_op   = MOP_A;
                n_acc3 = '0;
                n_c    = '0;
                n_dacc = '0;
            end
            ST_DWAIT: begin
                if (mul_done) begin
                    n_dacc = r_dacc + DW'(mul_p);
                    n_c    = r_c + 2'd1;
                end
            end
            ST_DET: begin
                n_det  = det_v;
                n_dsat = det_sat;
                n_k    = '0;
            end
            ST_QGO: begin
                n_neg  = r_cof_rd[COF_W-1] ^ r_det[COF_W-1];
                n_csel = r_csat[cof_raddr];
            end
            ST_QWAIT: begin
                if (div_done) begin
                    n_ovalid = 1'b1;
                    n_oval   = q_val;
                    n_orow   = r_k[3:2];
                    n_ocol   = r_k[1:0];
                    n_osing  = 1'b0;
                    n_osat   = q_sat | r_csel | r_dsat;
                    n_olast  = (r_k == 4'd15);
                    n_k      = r_k + 4'd1;
                    pop      = (r_k == 4'd15);
                end
            end
            ST_EMIT: begin
                n_ovalid = 1'b1;
                n_oval   = (r_k[3:2] == r_k[1:0]) ? ONE_VAL : '0;
                n_orow   = r_k[3:2];
                n_ocol   = r_k[1:0];
                n_osing  = 1'b1;
                n_osat   = (r_k[3:2] == r_k[1:0]) & ~ONE_FITS;
                n_olast  = (r_k == 4'd15);
                n_k      = r_k + 4'd1;
                pop      = (r_k == 4'd15);
            end
            default: begin
            end
        endcase
    end

    assign o_pop          = pop;
    assign o_valid        = r_ovalid;
    assign o_inv_value    = r_oval;
    assign o_out_row      = r_orow;
    assign o_out_col      = r_ocol;
    assign o_is_singular  = r_osing;
    assign o_did_saturate = r_osat;
    assign o_out_last     = r_olast;

    // Cofactor store: written once per cofactor, read registered
    always_ff @(posedge i_clk) begin
        if (r_state == ST_COF) begin
            r_cof[r_k]  <= cof_v;
            r_csat[r_k] <= cof_sat;
        end
        r_cof_rd <= r_cof[cof_raddr];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pa    <= n_pa;
        r_d     <= n_d;
        r_acc3  <= n_acc3;
        r_dacc  <= n_dacc;
        r_det   <= n_det;
        r_dsat  <= n_dsat;
        r_neg   <= n_neg;
        r_csel  <= n_csel;
        r_oval  <= n_oval;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_osing <= n_osing;
        r_osat  <= n_osat;
        r_olast <= n_olast;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= MOP_A;
            r_k      <= '0;
            r_t      <= '0;
            r_c      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_k      <= n_k;
            r_t      <= n_t;
            r_c      <= n_c;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
